// File: sv/blle_pkg.sv
package blle_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [2:0] {
    OP_PUSH_HEAD = 3'd0,
    OP_PUSH_TAIL = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_POP_TAIL  = 3'd3,
    OP_POP_POS   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_TAKE,
    S_LINK_NEW,
    S_POPH,
    S_POPH_FIN,
    S_RCUR,
    S_RNEXT,
    S_WPREV,
    S_WCUR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic value_we;
  } mem_ctl_t;

endpackage

// File: sv/blle_store.sv
module blle_store #(
  parameter int unsigned DEPTH = blle_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  blle_pkg::mem_ctl_t         mem_ctl_i,
  input  logic [AW-1:0]              rd_addr_i,
  input  logic [AW-1:0]              link_waddr_i,
  input  logic [AW-1:0]              link_wdata_i,
  input  logic [AW-1:0]              value_waddr_i,
  input  logic [blle_pkg::VAL_W-1:0] value_wdata_i,
  output logic [AW-1:0]              link_rdata_o,
  output logic [blle_pkg::VAL_W-1:0] value_rdata_o
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0]              link_mem [DEPTH];
  logic [blle_pkg::VAL_W-1:0] value_mem [DEPTH];

  logic [CW-1:0]              mark_q;
  logic [AW-1:0]              link_rd_q;
  logic [AW-1:0]              fresh_link_q;
  logic                       fresh_q;
  logic [blle_pkg::VAL_W-1:0] value_rd_q;

  // Slots at or above the mark were never taken and read as their reset link.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= '0;
    end else if (mem_ctl_i.value_we && (CW'(value_waddr_i) >= mark_q)) begin
      mark_q <= CW'(value_waddr_i) + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (mem_ctl_i.value_we) begin
      value_mem[value_waddr_i] <= value_wdata_i;
    end
    if (mem_ctl_i.rd_en) begin
      link_rd_q    <= link_mem[rd_addr_i];
      value_rd_q   <= value_mem[rd_addr_i];
      fresh_q      <= (CW'(rd_addr_i) >= mark_q);
      fresh_link_q <= (rd_addr_i == LAST_SLOT) ? '0 : rd_addr_i + AW'(1);
    end
  end

  assign link_rdata_o  = fresh_q ? fresh_link_q : link_rd_q;
  assign value_rdata_o = value_rd_q;

endmodule

// File: sv/blle_seq.sv
module blle_seq #(
  parameter int unsigned DEPTH = blle_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 in_opcode_i,
  input  logic [blle_pkg::VAL_W-1:0] in_value_i,
  input  logic [blle_pkg::POS_W-1:0] in_pos_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [blle_pkg::VAL_W-1:0] res_value_o,
  output blle_pkg::status_e          res_status_o,
  output logic [CW-1:0]              res_count_o,
  output blle_pkg::mem_ctl_t         mem_ctl_o,
  output logic [AW-1:0]              rd_addr_o,
  output logic [AW-1:0]              link_waddr_o,
  output logic [AW-1:0]              link_wdata_o,
  output logic [AW-1:0]              value_waddr_o,
  output logic [blle_pkg::VAL_W-1:0] value_wdata_o,
  input  logic [AW-1:0]              link_rdata_i,
  input  logic [blle_pkg::VAL_W-1:0] value_rdata_i
);

  localparam int unsigned CMPW     = (CW > blle_pkg::POS_W) ? CW : blle_pkg::POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  blle_pkg::state_e           state_q, state_d;
  logic [AW-1:0]              first_q, first_d;
  logic [AW-1:0]              free_q, free_d;
  logic [CW-1:0]              count_q, count_d;
  logic [AW-1:0]              ptr_q, ptr_d;
  logic [AW-1:0]              cur_q, cur_d;
  logic [CW-1:0]              steps_q, steps_d;
  logic                       pend_q, pend_d;
  logic                       tail_q, tail_d;
  logic [blle_pkg::VAL_W-1:0] val_q, val_d;
  logic [blle_pkg::VAL_W-1:0] res_q, res_d;
  blle_pkg::status_e          status_q, status_d;

  logic [AW-1:0]              walk_ptr;
  logic [CMPW-1:0]            pos_ext;
  logic [CMPW-1:0]            cnt_ext;

  assign pos_ext  = CMPW'(in_pos_i);
  assign cnt_ext  = CMPW'(count_q);
  assign walk_ptr = pend_q ? link_rdata_i : ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blle_pkg::S_IDLE;
      first_q <= '0;
      free_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
      tail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      free_q  <= free_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    cur_q    <= cur_d;
    steps_q  <= steps_d;
    val_q    <= val_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    first_d   = first_q;
    free_d    = free_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    cur_d     = cur_q;
    steps_d   = steps_q;
    pend_d    = pend_q;
    tail_d    = tail_q;
    val_d     = val_q;
    res_d     = res_q;
    status_d  = status_q;
    mem_ctl_o = '0;
    rd_addr_o     = ptr_q;
    link_waddr_o  = ptr_q;
    link_wdata_o  = free_q;
    value_waddr_o = free_q;
    value_wdata_o = val_q;
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;

    unique case (state_q)
      blle_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d    = '0;
          status_d = blle_pkg::ST_OK;
          val_d    = in_value_i;
          ptr_d    = first_q;
          pend_d   = 1'b0;
          tail_d   = 1'b0;
          state_d  = blle_pkg::S_DONE;
          case (blle_pkg::opcode_e'(in_opcode_i))
            blle_pkg::OP_PUSH_HEAD: begin
              if (count_q == FULL_CNT) begin
                status_d = blle_pkg::ST_FULL;
              end else begin
                state_d = blle_pkg::S_TAKE;
              end
            end
            blle_pkg::OP_PUSH_TAIL: begin
              if (count_q == '0) begin
                state_d = blle_pkg::S_TAKE;
              end else if (count_q == FULL_CNT) begin
                status_d = blle_pkg::ST_FULL;
              end else begin
                tail_d  = 1'b1;
                steps_d = count_q - CW'(1);
                state_d = blle_pkg::S_WALK;
              end
            end
            blle_pkg::OP_POP_HEAD: begin
              if (count_q == '0) begin
                status_d = blle_pkg::ST_EMPTY;
              end else begin
                state_d = blle_pkg::S_POPH;
              end
            end
            blle_pkg::OP_POP_TAIL: begin
              if (count_q == '0) begin
                status_d = blle_pkg::ST_EMPTY;
              end else if (count_q == CW'(1)) begin
                state_d = blle_pkg::S_POPH;
              end else begin
                steps_d = count_q - CW'(2);
                state_d = blle_pkg::S_WALK;
              end
            end
            blle_pkg::OP_POP_POS: begin
              if (count_q == '0) begin
                status_d = blle_pkg::ST_EMPTY;
              end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                status_d = blle_pkg::ST_BADPOS;
              end else if (pos_ext == CMPW'(1)) begin
                state_d = blle_pkg::S_POPH;
              end else begin
                steps_d = CW'(pos_ext - CMPW'(2));
                state_d = blle_pkg::S_WALK;
              end
            end
            default: begin
              state_d = blle_pkg::S_DONE;
            end
          endcase
        end
      end
      blle_pkg::S_WALK: begin
        ptr_d = walk_ptr;
        if (steps_q == '0) begin
          pend_d  = 1'b0;
          state_d = tail_q ? blle_pkg::S_TAKE : blle_pkg::S_RCUR;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = walk_ptr;
          steps_d         = steps_q - CW'(1);
          pend_d          = 1'b1;
        end
      end
      blle_pkg::S_TAKE: begin
        mem_ctl_o.rd_en    = 1'b1;
        mem_ctl_o.value_we = 1'b1;
        rd_addr_o          = free_q;
        state_d            = blle_pkg::S_LINK_NEW;
      end
      blle_pkg::S_LINK_NEW: begin
        mem_ctl_o.link_we = 1'b1;
        free_d            = link_rdata_i;
        count_d           = count_q + CW'(1);
        if (tail_q) begin
          link_waddr_o = ptr_q;
          link_wdata_o = free_q;
        end else begin
          link_waddr_o = free_q;
          link_wdata_o = first_q;
          first_d      = free_q;
        end
        state_d = blle_pkg::S_DONE;
      end
      blle_pkg::S_POPH: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = first_q;
        state_d         = blle_pkg::S_POPH_FIN;
      end
      blle_pkg::S_POPH_FIN: begin
        mem_ctl_o.link_we = 1'b1;
        link_waddr_o      = first_q;
        link_wdata_o      = free_q;
        free_d            = first_q;
        first_d           = link_rdata_i;
        res_d             = value_rdata_i;
        count_d           = count_q - CW'(1);
        state_d           = blle_pkg::S_DONE;
      end
      blle_pkg::S_RCUR: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = ptr_q;
        state_d         = blle_pkg::S_RNEXT;
      end
      blle_pkg::S_RNEXT: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = link_rdata_i;
        cur_d           = link_rdata_i;
        state_d         = blle_pkg::S_WPREV;
      end
      blle_pkg::S_WPREV: begin
        mem_ctl_o.link_we = 1'b1;
        link_waddr_o      = ptr_q;
        link_wdata_o      = link_rdata_i;
        res_d             = value_rdata_i;
        state_d           = blle_pkg::S_WCUR;
      end
      blle_pkg::S_WCUR: begin
        mem_ctl_o.link_we = 1'b1;
        link_waddr_o      = cur_q;
        link_wdata_o      = free_q;
        free_d            = cur_q;
        count_d           = count_q - CW'(1);
        state_d           = blle_pkg::S_DONE;
      end
      blle_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = blle_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = blle_pkg::S_IDLE;
      end
    endcase
  end

  assign res_value_o  = res_q;
  assign res_status_o = status_q;
  assign res_count_o  = count_q;

endmodule

// File: sv/bounded_linked_list_engine.sv
// Bounded singly linked list of up to DEPTH signed 32-bit values held in a
// slot memory with one link per slot. Each request word carries an opcode on
// s_axis_tuser (push head, push tail, pop head, pop tail, pop at a 1-based
// position) and answers with one result word: the removed value, a status on
// m_axis_tuser and the count after the request. One request is worked on at a
// time. A refused request or an unused opcode shows its result word without
// touching the memory. A push tail into an empty list and a pop tail of a
// single word count as head operations. Push tail, pop tail and pop at a
// position p of 2 or more walk the chain from the head, reading one link a
// cycle from the single read port of the link memory. The block takes the next
// request in the cycle after the result word moves to the output register.
// Slots that were never used are tracked by a high-water mark, so the block
// is ready directly after reset with no clearing pass. The result register
// lets the next request be taken while a result still waits on the master
// side.
module bounded_linked_list_engine #(
  parameter int unsigned DEPTH = blle_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // push_value [31:0], position [38:32]
  input  logic [2:0]  s_axis_tuser,  // opcode [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // popped_value [31:0], entry_count [38:32]
  output logic [1:0]  m_axis_tuser   // status [1:0]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  blle_pkg::mem_ctl_t         mem_ctl;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              link_waddr;
  logic [AW-1:0]              link_wdata;
  logic [AW-1:0]              value_waddr;
  logic [blle_pkg::VAL_W-1:0] value_wdata;
  logic [AW-1:0]              link_rdata;
  logic [blle_pkg::VAL_W-1:0] value_rdata;

  logic                       res_valid;
  logic                       res_ready;
  logic [blle_pkg::VAL_W-1:0] res_value;
  blle_pkg::status_e          res_status;
  logic [CW-1:0]              res_count;
  logic [CW+blle_pkg::CNT_OUT_W-1:0] count_ext;

  logic                           out_valid_q;
  logic [blle_pkg::VAL_W-1:0]     out_value_q;
  logic [blle_pkg::CNT_OUT_W-1:0] out_count_q;
  blle_pkg::status_e              out_status_q;

  blle_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_opcode_i   (s_axis_tuser),
    .in_value_i    (s_axis_tdata[31:0]),
    .in_pos_i      (s_axis_tdata[38:32]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_value_o   (res_value),
    .res_status_o  (res_status),
    .res_count_o   (res_count),
    .mem_ctl_o     (mem_ctl),
    .rd_addr_o     (rd_addr),
    .link_waddr_o  (link_waddr),
    .link_wdata_o  (link_wdata),
    .value_waddr_o (value_waddr),
    .value_wdata_o (value_wdata),
    .link_rdata_i  (link_rdata),
    .value_rdata_i (value_rdata)
  );

  blle_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mem_ctl_i     (mem_ctl),
    .rd_addr_i     (rd_addr),
    .link_waddr_i  (link_waddr),
    .link_wdata_i  (link_wdata),
    .value_waddr_i (value_waddr),
    .value_wdata_i (value_wdata),
    .link_rdata_o  (link_rdata),
    .value_rdata_o (value_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;
  assign count_ext = {{blle_pkg::CNT_OUT_W{1'b0}}, res_count};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_value_q  <= res_value;
      out_count_q  <= count_ext[blle_pkg::CNT_OUT_W-1:0];
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// File: dv/bounded_linked_list_engine_tb.sv
`timescale 1ns / 1ps

module bounded_linked_list_engine_tb;
  import blle_pkg::*;

  localparam int unsigned LIST_DEPTH   = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT     = 23;
  localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  OP_UNUSED_MID   = 3'd6;
  localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic        hold;
    logic [2:0]  opcode;
    logic [31:0] value;
    logic [6:0]  position;
  } list_req_t;

  typedef struct {
    logic [31:0] popped;
    status_e     status;
    logic [6:0]  count;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  list_req_t    pending[$];
  list_result_t results_due[$];
  logic [31:0]  list_vals[$];
  list_req_t    cur_req;

  logic        in_fire = 1'b0;
  logic        failed = 1'b0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  bounded_linked_list_engine #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic list_req_t request(logic [2:0] op, logic [31:0] val, logic [6:0] pos);
    list_req_t r;
    r.hold     = 1'b0;
    r.opcode   = op;
    r.value    = val;
    r.position = pos;
    return r;
  endfunction

  function automatic list_req_t sender_pause();
    list_req_t r;
    r = request(OP_PUSH_HEAD, '0, '0);
    r.hold = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // The slot layout never shows at the ports, so the list is kept as an
  // ordered queue of values.
  function automatic list_result_t apply_request(list_req_t req);
    list_result_t r;
    int unsigned n;
    r.popped = '0;
    r.status = ST_OK;
    n = list_vals.size();
    case (req.opcode)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (n >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (req.opcode == OP_PUSH_HEAD) begin
          list_vals.push_front(req.value);
        end else begin
          list_vals.push_back(req.value);
        end
      end
      OP_POP_HEAD, OP_POP_TAIL, OP_POP_POS: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (req.opcode == OP_POP_HEAD) begin
          r.popped = list_vals.pop_front();
        end else if (req.opcode == OP_POP_TAIL) begin
          r.popped = list_vals.pop_back();
        end else if (req.position < 1 || req.position > n) begin
          r.status = ST_BADPOS;
        end else begin
          r.popped = list_vals[req.position - 1];
          list_vals.delete(req.position - 1);
        end
      end
      default: begin
      end
    endcase
    r.count = 7'(list_vals.size());
    return r;
  endfunction

  always @(posedge clk_i) begin
    list_result_t want;
    logic         out_fire;
    out_fire = m_axis_tvalid && m_axis_tready;
    in_fire  = s_axis_tvalid && s_axis_tready;
    if (out_fire) begin
      n_results++;
      if (results_due.size() == 0) begin
        $error("result word with no request outstanding");
        failed = 1'b1;
      end else begin
        want = results_due.pop_front();
        if (m_axis_tdata[31:0] !== want.popped) begin
          $error("popped_value: expected %0d, got %0d",
                 $signed(want.popped), $signed(m_axis_tdata[31:0]));
          failed = 1'b1;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          failed = 1'b1;
        end
        if (m_axis_tdata[38:32] !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, m_axis_tdata[38:32]);
          failed = 1'b1;
        end
      end
    end
    if (in_fire) begin
      results_due.push_back(apply_request(cur_req));
      n_requests++;
    end
    if (in_fire || out_fire) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    logic quiet;
    logic next_valid;
    quiet = n_requests >= 700 && n_requests < 950;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      next_valid = 1'b0;
      if (pending.size() != 0) begin
        if (pending[0].hold) begin
          if (results_due.size() == 0) begin
            void'(pending.pop_front());
          end
        end else if (quiet || $urandom_range(0, 99) >= IDLE_PCT) begin
          cur_req = pending.pop_front();
          next_valid = 1'b1;
          s_axis_tdata <= {1'b0, cur_req.position, cur_req.value};
          s_axis_tuser <= cur_req.opcode;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  always @(negedge clk_i) begin
    logic quiet;
    logic ready;
    quiet = n_requests >= 700 && n_requests < 950;
    ready = 1'b1;
    if (hold_left != 0) begin
      hold_left--;
      ready = 1'b0;
    end else if (!hold_done && n_results >= 600) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      ready = 1'b0;
    end
    m_axis_tready <= ready;
  end

  initial begin
    int unsigned fill;
    int unsigned push_pct;
    int unsigned r;
    logic        growing;
    logic        removes;
    list_req_t   req;

    pending.push_back(request(OP_POP_HEAD, rand_value(), 7'd0));
    pending.push_back(request(OP_POP_TAIL, rand_value(), 7'd127));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd0));
    pending.push_back(request(OP_PUSH_TAIL, 32'h7FFF_FFFF, 7'd127));
    pending.push_back(request(OP_POP_HEAD, rand_value(), 7'd0));
    pending.push_back(request(OP_PUSH_HEAD, 32'h8000_0000, 7'd0));
    pending.push_back(request(OP_POP_TAIL, rand_value(), 7'd0));
    pending.push_back(request(OP_PUSH_HEAD, 32'hFFFF_FFFF, 7'd127));
    pending.push_back(request(OP_PUSH_TAIL, 32'h0000_0000, 7'd0));
    pending.push_back(request(OP_PUSH_TAIL, 32'h8000_0000, 7'd0));
    pending.push_back(request(OP_PUSH_HEAD, 32'h7FFF_FFFF, 7'd0));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd0));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd5));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd127));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd4));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd2));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd1));
    pending.push_back(request(OP_UNUSED_FIRST, rand_value(), 7'd0));
    pending.push_back(request(OP_UNUSED_MID, 32'h0000_0000, 7'd64));
    pending.push_back(request(OP_UNUSED_LAST, 32'hFFFF_FFFF, 7'd127));
    pending.push_back(request(OP_POP_POS, rand_value(), 7'd1));
    pending.push_back(sender_pause());

    // Alternate between filling the list up to full and draining it to empty,
    // so that refused pushes, empty pops and long chain walks all recur.
    fill    = 0;
    growing = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 400 || i == 1000) begin
        pending.push_back(sender_pause());
      end
      if (fill == LIST_DEPTH && $urandom_range(0, 5) == 0) begin
        growing = 1'b0;
      end
      if (fill == 0 && $urandom_range(0, 3) == 0) begin
        growing = 1'b1;
      end
      push_pct = growing ? 70 : 30;
      r   = $urandom_range(0, 99);
      req = request(OP_PUSH_HEAD, rand_value(), 7'($urandom_range(0, 127)));
      if (r < 4) begin
        req.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else if (r < 4 + push_pct) begin
        req.opcode = $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
        if (fill < LIST_DEPTH) begin
          fill++;
        end
      end else begin
        removes = fill != 0;
        case ($urandom_range(0, 2))
          0: req.opcode = OP_POP_HEAD;
          1: req.opcode = OP_POP_TAIL;
          default: begin
            req.opcode = OP_POP_POS;
            if (fill != 0 && $urandom_range(0, 9) != 0) begin
              req.position = 7'($urandom_range(1, fill));
            end else begin
              case ($urandom_range(0, 2))
                0: req.position = 7'd0;
                1: req.position = 7'(fill + 1);
                default: req.position = 7'($urandom_range(0, 127));
              endcase
              removes = fill != 0 && req.position >= 1 && req.position <= fill;
            end
          end
        endcase
        if (removes) begin
          fill--;
        end
      end
      pending.push_back(req);
    end

    while (pending.size() != 0 || s_axis_tvalid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending.size() != 0 || results_due.size() != 0) begin
      $error("result words still outstanding at the end of the run");
      failed = 1'b1;
    end
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
